// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the serializer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define ASSERT_IMPLIES(name, clk, rst_n, a, c) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

// next-cycle implication, off while in reset
`define ASSERT_NEXT(name, clk, rst_n, a, c) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/lps_pkg.sv
// ----------------------------------------------------------------------------
// lps_pkg
// Types and constants shared by the LED pixel serializer modules.
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int FUNC_W = 2;
  localparam int IDX_W  = 6;
  localparam int COL_W  = 8;
  localparam int CNT_W  = 7;
  localparam int TCK_W  = 8;
  localparam int PIX_W  = 3 * COL_W;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 8;

  // input command codes
  localparam logic [FUNC_W-1:0] FN_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FN_START = 2'd1;
  localparam logic [FUNC_W-1:0] FN_TICK  = 2'd2;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_LED_COUNT   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_SLOT_PERIOD = 3'd1;
  localparam logic [CFG_AW-1:0] REG_ZERO_HIGH   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_ONE_HIGH    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_RESET_SLOTS = 3'd4;

  // register reset values
  localparam logic [CNT_W-1:0] RST_LED_COUNT   = 7'd60;
  localparam logic [TCK_W-1:0] RST_SLOT_PERIOD = 8'd59;
  localparam logic [TCK_W-1:0] RST_ZERO_HIGH   = 8'd12;
  localparam logic [TCK_W-1:0] RST_ONE_HIGH    = 8'd35;
  localparam logic [TCK_W-1:0] RST_RESET_SLOTS = 8'd50;

  typedef enum logic [1:0] {
    OP_NOP   = 2'd0,
    OP_WRITE = 2'd1,
    OP_START = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0] led_count;
    logic [TCK_W-1:0] slot_period;
    logic [TCK_W-1:0] zero_high;
    logic [TCK_W-1:0] one_high;
    logic [TCK_W-1:0] reset_slots;
  } cfg_t;

endpackage

// File: hw/rtl/led_pixel_serializer.sv
// ----------------------------------------------------------------------------
// led_pixel_serializer
// Frame store and one-wire bit-slot serializer for addressable RGB LEDs.
// ----------------------------------------------------------------------------
// Path: an input beat is parked in the queue, then popped into the registered
// result beat once the result register is free or being emptied.
// Throughput: one beat per cycle sustained while the result side keeps taking beats.
// Reset (rst_n low, synchronous): queue and result register empty, sequencer
// idle, pixel store reads as all zero (per-LED valid bits cleared at once),
// registers back to 60 / 59 / 12 / 35 / 50. No clearing pass is needed.
// ----------------------------------------------------------------------------
//
// Structure
//   lps_front : takes input beats, decodes func into an op (writes outside
//               the store become no-ops) and parks them in a 2-entry queue.
//   lps_back  : pops one op per cycle when the result register is free,
//               runs the idle / data / gap sequencer and loads the result.
//   top       : configuration registers and port packing.
//
// Pixel words are stored green:red:blue. During the data phase the current
// LED's word sits in a shift register; its MSB picks the high time of the
// slot. On the last slot of an LED the next word is read straight into it.

module led_pixel_serializer #(
  parameter int MAX_LEDS     = 64,
  parameter int BITS_PER_LED = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input beats
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [31:0]                in_tdata,  // led_index[5:0], red, green, blue, pad
  input  logic [1:0]                 in_tuser,  // func
  // result beats
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [7:0]                 out_tdata, // line_level, busy_res, pad
  output logic                       out_tlast, // frame_done
  // register writes
  input  logic                       cfg_we,
  input  logic [lps_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [lps_pkg::CFG_DW-1:0] cfg_wdata
);

  lps_pkg::cfg_t  cfg_r;
  logic           q_valid, q_pop;
  lps_pkg::item_t q_item;
  logic           line, busy, done;

  // register file; writes to unused indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.led_count   <= lps_pkg::RST_LED_COUNT;
      cfg_r.slot_period <= lps_pkg::RST_SLOT_PERIOD;
      cfg_r.zero_high   <= lps_pkg::RST_ZERO_HIGH;
      cfg_r.one_high    <= lps_pkg::RST_ONE_HIGH;
      cfg_r.reset_slots <= lps_pkg::RST_RESET_SLOTS;
    end else if (cfg_we) begin
      case (cfg_addr)
        lps_pkg::REG_LED_COUNT:   cfg_r.led_count   <= cfg_wdata[lps_pkg::CNT_W-1:0];
        lps_pkg::REG_SLOT_PERIOD: cfg_r.slot_period <= cfg_wdata;
        lps_pkg::REG_ZERO_HIGH:   cfg_r.zero_high   <= cfg_wdata;
        lps_pkg::REG_ONE_HIGH:    cfg_r.one_high    <= cfg_wdata;
        lps_pkg::REG_RESET_SLOTS: cfg_r.reset_slots <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lps_front #(
    .MAX_LEDS (MAX_LEDS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_func  (in_tuser),
    .in_idx   (in_tdata[5:0]),
    .in_red   (in_tdata[13:6]),
    .in_green (in_tdata[21:14]),
    .in_blue  (in_tdata[29:22]),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  lps_back #(
    .MAX_LEDS     (MAX_LEDS),
    .BITS_PER_LED (BITS_PER_LED)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_line  (line),
    .out_busy  (busy),
    .out_done  (done)
  );

  assign out_tdata = {6'd0, busy, line};
  assign out_tlast = done;

endmodule

// File: hw/rtl/lps_front.sv
// ----------------------------------------------------------------------------
// lps_front
// Accepts input beats, decodes the command and holds it in a 2-entry queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lps_front #(
  parameter int MAX_LEDS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [lps_pkg::FUNC_W-1:0] in_func,
  input  logic [lps_pkg::IDX_W-1:0]  in_idx,
  input  logic [lps_pkg::COL_W-1:0]  in_red,
  input  logic [lps_pkg::COL_W-1:0]  in_green,
  input  logic [lps_pkg::COL_W-1:0]  in_blue,
  output logic                       q_valid,
  input  logic                       q_pop,
  output lps_pkg::item_t             q_item
);

  lps_pkg::item_t entry_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push;
  lps_pkg::item_t dec;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = entry_r[rd_ptr_r];

  // decode; a write outside the store becomes a no-op
  always_comb begin
    dec.idx   = in_idx;
    dec.red   = in_red;
    dec.green = in_green;
    dec.blue  = in_blue;
    case (in_func)
      lps_pkg::FN_WRITE: begin
        dec.op = (32'(in_idx) < 32'(MAX_LEDS)) ? lps_pkg::OP_WRITE : lps_pkg::OP_NOP;
      end
      lps_pkg::FN_START: dec.op = lps_pkg::OP_START;
      lps_pkg::FN_TICK:  dec.op = lps_pkg::OP_TICK;
      default:           dec.op = lps_pkg::OP_NOP;
    endcase
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= dec;
    end
  end

  `ASSERT_NEXT(a_pop_drains, clk, rst_n, q_pop && !push, cnt_r == 2'($past(cnt_r) - 2'd1))

endmodule

// File: hw/rtl/lps_back.sv
// ----------------------------------------------------------------------------
// lps_back
// Pixel store, frame sequencer and registered result beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lps_back #(
  parameter int MAX_LEDS     = 64,
  parameter int BITS_PER_LED = 24
) (
  input  logic           clk,
  input  logic           rst_n,
  input  lps_pkg::cfg_t  cfg,
  input  logic           q_valid,
  output logic           q_pop,
  input  lps_pkg::item_t q_item,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_line,
  output logic           out_busy,
  output logic           out_done
);

  localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CW = $clog2(MAX_LEDS + 1);
  localparam int NW = (CW > lps_pkg::CNT_W) ? CW : lps_pkg::CNT_W;
  localparam int BW = $clog2(BITS_PER_LED);

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_DATA = 3'b010,
    PH_GAP  = 3'b100
  } phase_t;

  phase_t                    phase_r, phase_nxt;
  logic [CW-1:0]             led_r, led_nxt;
  logic [BW-1:0]             bit_r, bit_nxt;
  logic [lps_pkg::TCK_W-1:0] tick_r, tick_nxt;
  logic [lps_pkg::TCK_W-1:0] gap_r, gap_nxt;
  logic [lps_pkg::PIX_W-1:0] pix_r;
  logic [lps_pkg::PIX_W-1:0] mem [MAX_LEDS];
  logic [MAX_LEDS-1:0]       valid_r;

  logic                      out_valid_r, out_line_r, out_busy_r, out_done_r;
  logic                      exec;
  logic                      line_c, done_c;
  logic                      wr_en, ld_en, shift_en;
  logic [AW-1:0]             wr_addr, ld_addr;
  logic [NW-1:0]             n_leds, lc_ext;
  logic [CW-1:0]             led_inc;
  logic [lps_pkg::TCK_W-1:0] high;
  logic                      slot_end, bit_last, led_last, gap_last;

  assign exec  = q_valid && (!out_valid_r || out_ready);
  assign q_pop = exec;

  // LEDs per frame, clamped to 1..MAX_LEDS
  always_comb begin
    lc_ext = NW'(cfg.led_count);
    if (lc_ext == '0) begin
      n_leds = NW'(1);
    end else if (lc_ext > NW'(MAX_LEDS)) begin
      n_leds = NW'(MAX_LEDS);
    end else begin
      n_leds = lc_ext;
    end
  end

  assign led_inc  = led_r + CW'(1);
  assign high     = pix_r[lps_pkg::PIX_W-1] ? cfg.one_high : cfg.zero_high;
  assign slot_end = (tick_r >= cfg.slot_period);
  assign bit_last = ({1'b0, bit_r} + (BW+1)'(1)) >= (BW+1)'(BITS_PER_LED);
  assign led_last = NW'(led_inc) >= n_leds;
  assign gap_last = ({1'b0, gap_r} + 9'd1) >= {1'b0, cfg.reset_slots};
  assign wr_addr  = AW'(q_item.idx);

  always_comb begin
    phase_nxt = phase_r;
    led_nxt   = led_r;
    bit_nxt   = bit_r;
    tick_nxt  = tick_r;
    gap_nxt   = gap_r;
    line_c    = 1'b0;
    done_c    = 1'b0;
    wr_en     = 1'b0;
    ld_en     = 1'b0;
    shift_en  = 1'b0;
    ld_addr   = '0;
    if (exec) begin
      case (q_item.op)
        lps_pkg::OP_WRITE: begin
          wr_en = (phase_r == PH_IDLE);
        end
        lps_pkg::OP_START: begin
          if (phase_r == PH_IDLE) begin
            phase_nxt = PH_DATA;
            led_nxt   = '0;
            bit_nxt   = '0;
            tick_nxt  = '0;
            gap_nxt   = '0;
            ld_en     = 1'b1;
          end
        end
        lps_pkg::OP_TICK: begin
          if (phase_r == PH_DATA) begin
            line_c   = (tick_r < high);
            tick_nxt = slot_end ? '0 : tick_r + 8'd1;
            if (slot_end) begin
              if (!bit_last) begin
                bit_nxt  = bit_r + BW'(1);
                shift_en = 1'b1;
              end else begin
                bit_nxt = '0;
                if (!led_last) begin
                  led_nxt = led_inc;
                  ld_en   = 1'b1;
                  ld_addr = AW'(led_inc);
                end else begin
                  led_nxt = '0;
                  gap_nxt = '0;
                  if (cfg.reset_slots == '0) begin
                    phase_nxt = PH_IDLE;
                    done_c    = 1'b1;
                  end else begin
                    phase_nxt = PH_GAP;
                  end
                end
              end
            end
          end else if (phase_r == PH_GAP) begin
            tick_nxt = slot_end ? '0 : tick_r + 8'd1;
            if (slot_end) begin
              if (gap_last) begin
                gap_nxt   = '0;
                phase_nxt = PH_IDLE;
                done_c    = 1'b1;
              end else begin
                gap_nxt = gap_r + 8'd1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      led_r       <= '0;
      bit_r       <= '0;
      tick_r      <= '0;
      gap_r       <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      led_r   <= led_nxt;
      bit_r   <= bit_nxt;
      tick_r  <= tick_nxt;
      gap_r   <= gap_nxt;
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (exec) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // store write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {q_item.green, q_item.red, q_item.blue};
    end
  end

  // registered read into the bit shifter; unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (ld_en) begin
      pix_r <= valid_r[ld_addr] ? mem[ld_addr] : '0;
    end else if (shift_en) begin
      pix_r <= {pix_r[lps_pkg::PIX_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_line_r <= line_c;
      out_busy_r <= (phase_nxt != PH_IDLE) || done_c;
      out_done_r <= done_c;
    end
  end

  assign out_valid = out_valid_r;
  assign out_line  = out_line_r;
  assign out_busy  = out_busy_r;
  assign out_done  = out_done_r;

  `ASSERT_NEXT(a_done_idle, clk, rst_n, exec && done_c, phase_r == PH_IDLE)
  `ASSERT_IMPLIES(a_led_range, clk, rst_n, phase_r == PH_DATA, led_r < CW'(MAX_LEDS))
  `ASSERT_IMPLIES(a_out_hold, clk, rst_n, out_valid_r && !out_ready, !exec)

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: LED pixel serializer testbench
// Drives pixel writes, frame starts and timer ticks into the stream input and
// checks every result beat (line level, busy, frame done) against an in-bench
// model of the frame store and bit-slot sequencer. A short scripted opening
// at the reset settings (frame cut short by register writes mid-frame) is
// followed by corner register settings, a widest-slot frame and then random small frames, with
// random idling on both stream sides.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LEDS         = 64;
  localparam int BITS_PER_LED = 24;

  // func value 3 has no meaning; the block treats it as a no-op
  localparam logic [lps_pkg::FUNC_W-1:0] FN_SPARE  = 2'd3;
  // an index past the last register; writes there must change nothing
  localparam logic [lps_pkg::CFG_AW-1:0] REG_SPARE = 3'd7;

  // Longest quiet stretch is the receiver hold-off (HOLD_LEN) plus a few
  // idle cycles; every beat yields exactly one result, so nothing else
  // should keep both channels silent for long.
  localparam int HOLD_AT       = 800;
  localparam int HOLD_LEN      = 200;
  localparam int QUIET_LIMIT   = 2000;
  localparam int RAND_BEATS    = 600;
  localparam int DEFAULT_TICKS = 130;
  localparam int WIDE_TICKS    = 300;

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'd0,
    SEQ_DATA = 2'd1,
    SEQ_GAP  = 2'd2
  } seq_t;

  typedef struct packed {
    logic line;
    logic busy;
    logic done;
  } led_res_t;

  typedef struct packed {
    logic [lps_pkg::FUNC_W-1:0] fn;
    logic [lps_pkg::IDX_W-1:0]  idx;
    logic [lps_pkg::COL_W-1:0]  red;
    logic [lps_pkg::COL_W-1:0]  green;
    logic [lps_pkg::COL_W-1:0]  blue;
    logic                       typed;  // row carries a hand-written expectation
    led_res_t                   want;
  } beat_row_t;

  typedef struct packed {
    logic [7:0] cnt;
    logic [7:0] per;
    logic [7:0] zero_hi;
    logic [7:0] one_hi;
    logic [7:0] gap;
  } setting_t;

  // mid-frame cuts: one short LED after the default frame's first slots,
  // and a short slot after the first 256-tick slot
  localparam setting_t DEFAULT_CUT = '{8'd1, 8'd1,   8'd0,   8'd1, 8'd2};
  localparam setting_t WIDE_SLOT   = '{8'd1, 8'd255, 8'd255, 8'd0, 8'd0};
  localparam setting_t WIDE_CUT    = '{8'd1, 8'd1,   8'd1,   8'd2, 8'd1};

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_tvalid;
  logic                         in_tready;
  logic [31:0]                  in_tdata;   // led_index[5:0], red, green, blue, pad
  logic [1:0]                   in_tuser;   // func
  logic                         out_tvalid;
  logic                         out_tready;
  logic [7:0]                   out_tdata;  // line_level, busy_res, pad
  logic                         out_tlast;  // frame_done
  logic                         cfg_we;
  logic [lps_pkg::CFG_AW-1:0]   cfg_addr;
  logic [lps_pkg::CFG_DW-1:0]   cfg_wdata;

  // sideband travelling with each input beat: typed expectation, if any
  logic                         beat_fixed;
  led_res_t                     beat_want;

  // shadow of the block: pixel store, sequencer and registers
  logic [lps_pkg::PIX_W-1:0]    pix_mem [LEDS];
  seq_t                         seq;
  int unsigned                  led_ctr;
  int unsigned                  bit_ctr;
  logic [lps_pkg::TCK_W-1:0]    tick_ctr;
  int unsigned                  gap_ctr;
  lps_pkg::cfg_t                shadow;

  led_res_t                     pending_q [$];
  int unsigned                  errors;
  int unsigned                  beats_sent;
  int unsigned                  results_seen;
  int unsigned                  quiet_cycles;
  bit                           gaps_on = 1'b1;

  always #2 clk = ~clk;

  led_pixel_serializer #(
    .MAX_LEDS     (LEDS),
    .BITS_PER_LED (BITS_PER_LED)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Opening script, all at the reset settings (60 LEDs, 60-tick slots,
  // 12/35 high ticks, 50 gap slots). LED 0 gets green 0x80 so the very
  // first slot of the frame is a one bit.
  localparam int SCRIPT_ROWS = 11;
  beat_row_t script [SCRIPT_ROWS] = '{
    // fn idx red green blue typed line busy done
    '{lps_pkg::FN_TICK, 6'd0, 8'h00, 8'h00, 8'h00, 1'b1, '{1'b0, 1'b0, 1'b0}}, // idle tick
    '{FN_SPARE, 6'd0, 8'h00, 8'h00, 8'h00, 1'b1, '{1'b0, 1'b0, 1'b0}}, // no-op code
    '{lps_pkg::FN_WRITE, 6'd63, 8'hff, 8'hff, 8'hff, 1'b1, '{1'b0, 1'b0, 1'b0}}, // top LED
    '{lps_pkg::FN_WRITE, 6'd0, 8'h01, 8'h80, 8'h00, 1'b1, '{1'b0, 1'b0, 1'b0}},
    '{lps_pkg::FN_START, 6'd0, 8'h00, 8'h00, 8'h00, 1'b1, '{1'b0, 1'b1, 1'b0}},
    '{lps_pkg::FN_TICK, 6'd0, 8'h00, 8'h00, 8'h00, 1'b1, '{1'b1, 1'b1, 1'b0}}, // one bit
    '{lps_pkg::FN_WRITE, 6'd0, 8'h00, 8'h00, 8'h00, 1'b1, '{1'b0, 1'b1, 1'b0}}, // busy
    '{lps_pkg::FN_START, 6'd0, 8'h00, 8'h00, 8'h00, 1'b1, '{1'b0, 1'b1, 1'b0}}, // busy
    '{FN_SPARE, 6'd0, 8'h00, 8'h00, 8'h00, 1'b1, '{1'b0, 1'b1, 1'b0}},
    '{lps_pkg::FN_TICK, 6'd0, 8'h00, 8'h00, 8'h00, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{lps_pkg::FN_TICK, 6'd0, 8'h00, 8'h00, 8'h00, 1'b0, '{1'b0, 1'b0, 1'b0}}
  };

  // Corner settings, one frame each:
  //   short slot with no gap; LED count 0 (sends one LED); count field all
  //   ones (clamps to 64) on one-tick slots with a one-bit high time past
  //   the slot; count with bit 7 set (masked to 3) and the longest gap.
  setting_t corner_plan [4] = '{
    '{8'd1,   8'd1,   8'd0,   8'd1,   8'd0},
    '{8'd0,   8'd2,   8'd1,   8'd2,   8'd2},
    '{8'hff,  8'd0,   8'd0,   8'd255, 8'd1},
    '{8'h83,  8'd0,   8'd0,   8'd1,   8'd255}
  };

  // ------------------------------------------------------------------
  // Shadow model
  // ------------------------------------------------------------------

  function automatic int unsigned frame_leds();
    if (shadow.led_count == '0) return 1;
    if (shadow.led_count > LEDS) return LEDS;
    return shadow.led_count;
  endfunction

  // step the slot timer; 1 when this tick closes the slot
  function automatic bit slot_over();
    if (tick_ctr >= shadow.slot_period) begin
      tick_ctr = '0;
      return 1'b1;
    end
    tick_ctr++;
    return 1'b0;
  endfunction

  function automatic led_res_t serialize_step(beat_row_t b);
    led_res_t                  res;
    logic                      bit_val;
    logic [lps_pkg::TCK_W-1:0] high_ticks;
    res = '0;
    case (b.fn)
      lps_pkg::FN_WRITE: begin
        if (seq == SEQ_IDLE) pix_mem[b.idx] = {b.green, b.red, b.blue};
      end
      lps_pkg::FN_START: begin
        if (seq == SEQ_IDLE) begin
          seq      = SEQ_DATA;
          led_ctr  = 0;
          bit_ctr  = 0;
          tick_ctr = '0;
          gap_ctr  = 0;
        end
      end
      lps_pkg::FN_TICK: begin
        if (seq == SEQ_DATA) begin
          // slots past the stored word send zero bits
          bit_val = 1'b0;
          if (bit_ctr < lps_pkg::PIX_W) begin
            bit_val = pix_mem[led_ctr][lps_pkg::PIX_W-1-bit_ctr];
          end
          high_ticks = bit_val ? shadow.one_high : shadow.zero_high;
          res.line = (tick_ctr < high_ticks);
          if (slot_over()) begin
            bit_ctr++;
            if (bit_ctr >= BITS_PER_LED) begin
              bit_ctr = 0;
              led_ctr++;
              if (led_ctr >= frame_leds()) begin
                led_ctr = 0;
                gap_ctr = 0;
                // no gap slots: done lands on the last data tick
                if (shadow.reset_slots == '0) begin
                  seq      = SEQ_IDLE;
                  res.done = 1'b1;
                end else begin
                  seq = SEQ_GAP;
                end
              end
            end
          end
        end else if (seq == SEQ_GAP) begin
          if (slot_over()) begin
            gap_ctr++;
            if (gap_ctr >= shadow.reset_slots) begin
              gap_ctr  = 0;
              seq      = SEQ_IDLE;
              res.done = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    // done only ever fires on the tick that drops back to idle
    res.busy = (seq != SEQ_IDLE) || res.done;
    return res;
  endfunction

  // ------------------------------------------------------------------
  // Monitor: register writes, input beats and result beats at posedge
  // ------------------------------------------------------------------

  task automatic report_mismatch(string what, logic got, logic want);
    $display("result %0d: %s got %0b want %0b", results_seen, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    led_res_t  got;
    led_res_t  want;
    beat_row_t taken;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.line = out_tdata[0];
        got.busy = out_tdata[1];
        got.done = out_tlast;
        if (pending_q.size() == 0) begin
          report_mismatch("beat with nothing pending", 1'b1, 1'b0);
        end else begin
          want = pending_q.pop_front();
          if (got.line != want.line) report_mismatch("line_level", got.line, want.line);
          if (got.busy != want.busy) report_mismatch("busy_res", got.busy, want.busy);
          if (got.done != want.done) report_mismatch("frame_done", got.done, want.done);
        end
        results_seen++;
      end

      if (cfg_we) begin
        case (cfg_addr)
          lps_pkg::REG_LED_COUNT:   shadow.led_count   = cfg_wdata[lps_pkg::CNT_W-1:0];
          lps_pkg::REG_SLOT_PERIOD: shadow.slot_period = cfg_wdata;
          lps_pkg::REG_ZERO_HIGH:   shadow.zero_high   = cfg_wdata;
          lps_pkg::REG_ONE_HIGH:    shadow.one_high    = cfg_wdata;
          lps_pkg::REG_RESET_SLOTS: shadow.reset_slots = cfg_wdata;
          default: ;
        endcase
      end

      if (in_tvalid && in_tready) begin
        taken       = '0;
        taken.fn    = in_tuser;
        taken.idx   = in_tdata[5:0];
        taken.red   = in_tdata[13:6];
        taken.green = in_tdata[21:14];
        taken.blue  = in_tdata[29:22];
        want = serialize_step(taken);
        // scripted rows check against the typed value; the model still steps
        pending_q.push_back(beat_fixed ? beat_want : want);
      end

      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("led_pixel_serializer verification failed");
          $finish;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Result side: random stall per beat, one long hold-off mid-run
  // ------------------------------------------------------------------

  initial begin : result_sink
    int  stall;
    bit  held;
    held = 1'b0;
    out_tready <= 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      // long hold-off while the sender keeps streaming: queue fills and
      // in_tready has to drop
      if (!held && results_seen >= HOLD_AT) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
      end
      stall = gaps_on ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // ------------------------------------------------------------------
  // Input side helpers; all are entered and left just after a negedge
  // ------------------------------------------------------------------

  task automatic send_beat(beat_row_t row);
    int gap;
    gap = gaps_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid  <= 1'b1;
    in_tuser   <= row.fn;
    in_tdata   <= {2'b00, row.blue, row.green, row.red, row.idx};
    beat_fixed <= row.typed;
    beat_want  <= row.want;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
    @(negedge clk);
  endtask

  function automatic beat_row_t rand_row(logic [lps_pkg::FUNC_W-1:0] fn);
    beat_row_t row;
    row       = '0;
    row.fn    = fn;
    row.idx   = $urandom_range(0, LEDS - 1);
    row.red   = $urandom_range(0, 255);
    row.green = $urandom_range(0, 255);
    row.blue  = $urandom_range(0, 255);
    return row;
  endfunction

  function automatic logic [lps_pkg::FUNC_W-1:0] noise_fn();
    case ($urandom_range(0, 2))
      0:       return lps_pkg::FN_WRITE;
      1:       return lps_pkg::FN_START;
      default: return FN_SPARE;
    endcase
  endfunction

  // ticks until the frame and its gap are over; stray commands mixed in
  task automatic drain_frame(bit noisy);
    while (seq != SEQ_IDLE) begin
      if (noisy && $urandom_range(0, 15) == 0) send_beat(rand_row(noise_fn()));
      else send_beat(rand_row(lps_pkg::FN_TICK));
    end
  endtask

  // stop offering beats and let every pending result come back
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [lps_pkg::CFG_AW-1:0] addr,
                           logic [lps_pkg::CFG_DW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  task automatic apply_settings(setting_t s);
    settle();
    write_reg(lps_pkg::REG_LED_COUNT,   s.cnt);
    write_reg(lps_pkg::REG_SLOT_PERIOD, s.per);
    write_reg(lps_pkg::REG_ZERO_HIGH,   s.zero_hi);
    write_reg(lps_pkg::REG_ONE_HIGH,    s.one_hi);
    write_reg(lps_pkg::REG_RESET_SLOTS, s.gap);
    write_reg(REG_SPARE,                $urandom_range(0, 255));
    cfg_we <= 1'b0;
  endtask

  // a few pixel writes, mostly inside the frame, then a full frame
  task automatic run_frame();
    beat_row_t row;
    repeat ($urandom_range(0, 4)) begin
      row = rand_row(lps_pkg::FN_WRITE);
      if ($urandom_range(0, 3) != 0) row.idx = $urandom_range(0, frame_leds() - 1);
      send_beat(row);
    end
    // idle noise: no-op code or a tick with nothing to send
    if ($urandom_range(0, 3) == 0) send_beat(rand_row(FN_SPARE));
    if ($urandom_range(0, 3) == 0) send_beat(rand_row(lps_pkg::FN_TICK));
    send_beat(rand_row(lps_pkg::FN_START));
    drain_frame(1'b1);
  endtask

  // ------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------

  initial begin : stimulus
    int unsigned rand_base;
    setting_t    s;
    beat_row_t   row;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    cfg_we     <= 1'b0;
    cfg_addr   <= '0;
    cfg_wdata  <= '0;
    beat_fixed <= 1'b0;
    beat_want  <= '0;
    foreach (pix_mem[i]) pix_mem[i] = '0;
    seq      = SEQ_IDLE;
    led_ctr  = 0;
    bit_ctr  = 0;
    tick_ctr = '0;
    gap_ctr  = 0;
    shadow   = '{lps_pkg::RST_LED_COUNT, lps_pkg::RST_SLOT_PERIOD,
                 lps_pkg::RST_ZERO_HIGH, lps_pkg::RST_ONE_HIGH,
                 lps_pkg::RST_RESET_SLOTS};
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) send_beat(script[i]);
    // the first slots of the 60-LED default frame, streamed back to back;
    // then registers shrink the running frame to one LED on short slots
    gaps_on = 1'b0;
    repeat (DEFAULT_TICKS) send_beat(rand_row(lps_pkg::FN_TICK));
    gaps_on = 1'b1;
    apply_settings(DEFAULT_CUT);
    drain_frame(1'b0);

    foreach (corner_plan[p]) begin
      apply_settings(corner_plan[p]);
      run_frame();
    end

    // widest slot, zero-bit high 255 and one-bit high 0: one full slot of
    // 256 ticks, then the slot is shortened for the rest of the frame
    apply_settings(WIDE_SLOT);
    row          = rand_row(lps_pkg::FN_WRITE);
    row.idx      = '0;
    row.green[7] = 1'b1;
    send_beat(row);
    send_beat(rand_row(lps_pkg::FN_START));
    repeat (WIDE_TICKS) send_beat(rand_row(lps_pkg::FN_TICK));
    apply_settings(WIDE_CUT);
    drain_frame(1'b1);

    // random small frames: short slots and few LEDs keep frames cheap
    rand_base = beats_sent;
    while (beats_sent - rand_base < RAND_BEATS) begin
      s.cnt     = $urandom_range(0, 3);
      s.per     = $urandom_range(0, 4);
      s.zero_hi = $urandom_range(0, 5);
      s.one_hi  = $urandom_range(0, 5);
      s.gap     = $urandom_range(0, 3);
      apply_settings(s);
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 3)) run_frame();
    end

    gaps_on = 1'b1;
    settle();
    if (errors == 0) begin
      $display("led_pixel_serializer verification clean");
    end else begin
      $display("led_pixel_serializer verification failed");
    end
    $finish;
  end

endmodule
